// ===== rtl/cuc_pkg.sv =====
// Shared constants, types and helper functions for the codon usage counter.
package cuc_pkg;

    // Sizing of the histogram store
    localparam int NUM_SEQUENCES = 1024;
    localparam int COUNT_WIDTH   = 32;
    localparam int NUM_BINS      = 64;
    localparam int HIST_DEPTH    = NUM_SEQUENCES * NUM_BINS;
    localparam int ADDR_W        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

    // Fixed field widths
    localparam int BASE_W  = 8;
    localparam int SEQ_W   = 10;
    localparam int BIN_W   = 6;
    localparam int OFF_W   = 32;
    localparam int OCNT_W  = 32;
    localparam int CODON_W = 6;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 80;

    // ASCII characters of interest
    localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
    localparam logic [BASE_W-1:0] CHAR_T = 8'h54;
    localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
    localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
    localparam logic [BASE_W-1:0] CHAR_N = 8'h4E;

    // Two-bit base codes
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_T = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_C = 2'd3;

    // Stop codons that raise a warning
    localparam logic [CODON_W-1:0] CODON_TAA = 6'd16;
    localparam logic [CODON_W-1:0] CODON_TAG = 6'd18;

    // Item modes
    localparam logic MODE_BASE = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Command handed from the framer to the histogram update stage
    typedef struct packed {
        logic                     wr;        // commit increments the bin
        logic                     is_read;   // read mode, bin value returned
        logic [ADDR_W-1:0]        addr;      // histogram entry touched
        logic                     counted;
        logic [CODON_W-1:0]       codon;
        logic                     stop;
        logic [OFF_W-1:0]         woff;
        logic                     bad;
    } t_cmd;

    // Histogram entry address from sequence and bin
    function automatic logic [ADDR_W-1:0] hist_addr(input logic [SEQ_W-1:0] seq,
                                                     input logic [BIN_W-1:0] bin);
        logic [SEQ_W+BIN_W-1:0] full;
        full = {seq, bin};
        return ADDR_W'(full);
    endfunction

endpackage

// ===== rtl/cuc_framer.sv =====
// Codon assembly in frame 0, pending-codon tracking and histogram command issue.
module cuc_framer
    import cuc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_mode,
    input  logic [BASE_W-1:0] i_base,
    input  logic [SEQ_W-1:0]  i_seq_index,
    input  logic              i_end_of_seq,
    input  logic [BIN_W-1:0]  i_bin_select,
    output t_cmd              o_cmd
);

    logic [1:0]       r_phase, n_phase;
    logic [6:0]       r_partial, n_partial;
    logic [6:0]       r_pend, n_pend;
    logic             r_pend_valid, n_pend_valid;
    logic [OFF_W-1:0] r_pend_off, n_pend_off;
    logic [OFF_W-1:0] r_char_off, n_char_off;

    logic [1:0] code;
    logic       code_inv;
    logic [6:0] prev;
    logic [6:0] new_partial;
    logic       complete;
    logic       seq_ok;
    logic       commit;
    logic [CODON_W-1:0] pc;

    // Base decode
    always_comb begin
        code_inv = 1'b0;
        case (i_base)
            CHAR_A:  code = CODE_A;
            CHAR_T:  code = CODE_T;
            CHAR_G:  code = CODE_G;
            CHAR_C:  code = CODE_C;
            default: begin
                code     = CODE_A;
                code_inv = 1'b1;
            end
        endcase
    end

    assign seq_ok      = (32'(i_seq_index) < 32'(NUM_SEQUENCES));
    assign prev        = (r_phase == 2'd0) ? 7'd0 : r_partial;
    assign new_partial = {prev[6] | code_inv, prev[3:0], code};
    assign complete    = (r_phase == 2'd2);
    assign pc          = r_pend[CODON_W-1:0];
    assign commit      = (i_mode == MODE_BASE) && complete && r_pend_valid
                         && !r_pend[6] && seq_ok;

    // Command toward the histogram
    always_comb begin
        o_cmd         = '0;
        o_cmd.wr      = commit;
        o_cmd.is_read = (i_mode == MODE_READ) && seq_ok;
        o_cmd.addr    = (i_mode == MODE_READ) ? hist_addr(i_seq_index, i_bin_select)
                                              : hist_addr(i_seq_index, pc);
        o_cmd.counted = commit;
        o_cmd.codon   = commit ? pc : '0;
        o_cmd.stop    = commit && ((pc == CODON_TAA) || (pc == CODON_TAG));
        o_cmd.woff    = o_cmd.stop ? r_pend_off : '0;
        o_cmd.bad     = (i_mode == MODE_BASE) && code_inv && (i_base != CHAR_N);
    end

    // Next framing state
    always_comb begin
        n_phase      = r_phase;
        n_partial    = r_partial;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_pend_off   = r_pend_off;
        n_char_off   = r_char_off;
        if (i_accept && (i_mode == MODE_BASE)) begin
            n_partial  = new_partial;
            n_char_off = r_char_off + 1'b1;
            if (complete) begin
                n_phase      = 2'd0;
                n_pend       = new_partial;
                n_pend_valid = 1'b1;
                n_pend_off   = r_char_off - 32'd2;
            end else begin
                n_phase = r_phase + 1'b1;
            end
            if (i_end_of_seq) begin
                n_phase      = 2'd0;
                n_partial    = '0;
                n_pend       = '0;
                n_pend_valid = 1'b0;
                n_pend_off   = '0;
                n_char_off   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_partial    <= '0;
            r_pend       <= '0;
            r_pend_valid <= 1'b0;
            r_pend_off   <= '0;
            r_char_off   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_partial    <= n_partial;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_pend_off   <= n_pend_off;
            r_char_off   <= n_char_off;
        end
    end

endmodule

// ===== rtl/cuc_hist_ram.sv =====
// Histogram store: one write port and one registered read port.
module cuc_hist_ram
    import cuc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_wr_en,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    input  logic [COUNT_WIDTH-1:0] i_wr_data,
    input  logic                   i_rd_en,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);

    logic [COUNT_WIDTH-1:0] r_mem [HIST_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, old data on a same-cycle write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/codon_usage_counter.sv =====
// Top level: stream ports, histogram clear sweep, read-modify-write stage, output register.
//
// Codon usage counter. Slave stream: one item per nucleotide character or
// histogram read; tuser is the mode (0 = character, 1 = read a bin), tlast
// marks the last character of a sequence. Master stream: exactly one result
// item per input item, in order.
// An accepted item's bin read and command are registered, then pass the output register.
// Throughput: one item per cycle when not stalled or clearing. Each item
// does one read of the histogram memory and at most one write back; a
// one-entry forward path covers a write landing in the same cycle as the
// next item's read of that bin.
// Reset: framing state is cleared at once, then the histogram is swept to
// zero one entry per cycle, all NUM_SEQUENCES*64 entries (65536 as built),
// while o_s_axis_tready is low.
// Stalls: when the receiver holds i_m_axis_tready low with a result waiting,
// the pipeline freezes and o_s_axis_tready drops; nothing is lost or repeated.
module codon_usage_counter
    import cuc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // base[7:0], seq_index[17:8], bin_select[23:18]
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // mode
    input  logic                i_s_axis_tuser,
    input  logic                i_s_axis_tlast,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // counted[0], counted_codon[6:1], stop_warning[7], warning_offset[39:8],
    // bad_symbol[40], bin_count[72:41], zero[79:73]
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    logic                   adv;
    logic                   accept;
    t_cmd                   cmd;

    logic                   r_clearing;
    logic [ADDR_W:0]        r_clr_cnt;

    logic                   r_s1_valid;
    t_cmd                   r_s1;

    logic                   r_fw_valid;
    logic [ADDR_W-1:0]      r_fw_addr;
    logic [COUNT_WIDTH-1:0] r_fw_data;

    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] upd;
    logic                   upd_wr;

    logic                   mem_wr_en;
    logic [ADDR_W-1:0]      mem_wr_addr;
    logic [COUNT_WIDTH-1:0] mem_wr_data;

    logic                   r_out_valid;
    logic [M_DATA_W-1:0]    r_out_data;
    logic [M_DATA_W-1:0]    n_out_data;

    // Handshake
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv && !r_clearing;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    cuc_framer u_framer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_mode       (i_s_axis_tuser),
        .i_base       (i_s_axis_tdata[7:0]),
        .i_seq_index  (i_s_axis_tdata[17:8]),
        .i_end_of_seq (i_s_axis_tlast),
        .i_bin_select (i_s_axis_tdata[23:18]),
        .o_cmd        (cmd)
    );

    // Clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == (ADDR_W+1)'(HIST_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Read data, forwarded when the previous write hit the same entry
    assign cur    = (r_fw_valid && (r_fw_addr == r_s1.addr)) ? r_fw_data : rd_data;
    assign upd    = (cur == COUNT_MAX) ? cur : cur + 1'b1;
    assign upd_wr = adv && r_s1_valid && r_s1.wr;

    // Write port mux: clear sweep or increment
    always_comb begin
        if (r_clearing) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = r_clr_cnt[ADDR_W-1:0];
            mem_wr_data = '0;
        end else begin
            mem_wr_en   = upd_wr;
            mem_wr_addr = r_s1.addr;
            mem_wr_data = upd;
        end
    end

    cuc_hist_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (cmd.addr),
        .o_rd_data (rd_data)
    );

    // Update stage and forward register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fw_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_fw_valid <= upd_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= cmd;
            r_fw_addr <= r_s1.addr;
            r_fw_data <= upd;
        end
    end

    // Result packing
    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = r_s1.counted;
        n_out_data[6:1]   = r_s1.codon;
        n_out_data[7]     = r_s1.stop;
        n_out_data[39:8]  = r_s1.woff;
        n_out_data[40]    = r_s1.bad;
        n_out_data[72:41] = r_s1.is_read ? OCNT_W'(cur) : '0;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
